### rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the noise block.
// Depends on nothing; each macro takes a label, clock, active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GNT_ASSERT_IMP(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication
`define GNT_ASSERT_NXT(lbl, ck, rn, a, c) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
		else $error("assertion failed");

`endif

### rtl/gnt_pkg.sv
// Package for the gradient noise block: field widths, defaults, command and state codes.
// Depends on nothing.
`timescale 1ns / 1ps

package gnt_pkg;

	localparam int TABLE_SIZE_DEF = 256;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int MAX_OCT_DEF    = 8;

	localparam int COORD_W    = 32;
	localparam int GRAD_W     = 16;
	localparam int PERM_W     = 8;
	localparam int IDX_W      = 8;
	localparam int OUT_W      = 18;
	localparam int CMD_W      = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 4;
	localparam int OCT_CNT_W  = 4;

	localparam int OUT_MAX = 131071;
	localparam int OUT_MIN = -131072;

	localparam logic [CFG_IDX_W-1:0] CFG_TURB = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OCT  = 2'd1;
	localparam logic [OCT_CNT_W-1:0] OCT_CNT_RST = 4'd7;

	typedef enum logic [CMD_W-1:0] {
		CMD_EVAL      = 3'd0,
		CMD_LOAD_PX   = 3'd1,
		CMD_LOAD_PY   = 3'd2,
		CMD_LOAD_PZ   = 3'd3,
		CMD_LOAD_GRAD = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LDW,
		S_RUN,
		S_FIN
	} state_t;

endpackage

### rtl/gnt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module gnt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/gradient_noise_turbulence.sv
// Top level of the 3D gradient noise / turbulence block: sequencer, smoothing, corner datapath.
// Depends on gnt_pkg, gnt_ram and assert_macros.svh.
//
//   channel   handshake          payload
//   item in   start / busy       cmd, coord_x/y/z, entry_index, perm_entry, grad_x/y/z
//   result    done (1 cycle)     noise_value
//   config    cfg_we             cfg_index, cfg_data
//
// Gradient loads write the gradient memory in the accepting cycle; perm loads do a
// read-modify-write of the shared perm memory, busy high for one cycle. An evaluate runs
// one pass per octave (six perm reads, eight gradient reads through a four-stage corner
// pipeline) plus a finishing state: one octave in plain mode, n octaves in turbulence mode.
// Tables are not cleared by reset. The receiver cannot stall; done pulses once per evaluate.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gradient_noise_turbulence
	import gnt_pkg::*;
#(
	parameter int TABLE_SIZE  = TABLE_SIZE_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int MAX_OCTAVES = MAX_OCT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	output logic                         done,
	input  logic [CMD_W-1:0]             cmd,
	input  logic signed [COORD_W-1:0]    coord_x,
	input  logic signed [COORD_W-1:0]    coord_y,
	input  logic signed [COORD_W-1:0]    coord_z,
	input  logic [IDX_W-1:0]             entry_index,
	input  logic [PERM_W-1:0]            perm_entry,
	input  logic signed [GRAD_W-1:0]     grad_x,
	input  logic signed [GRAD_W-1:0]     grad_y,
	input  logic signed [GRAD_W-1:0]     grad_z,
	output logic signed [OUT_W-1:0]     noise_value,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int TW  = $clog2(TABLE_SIZE);
	localparam int HW  = (TW > PERM_W) ? TW : PERM_W;
	localparam int XW  = (TW > IDX_W) ? TW : IDX_W;
	localparam int FB  = FRAC_BITS;
	localparam int CW  = FB + TW;
	localparam int OW  = FB + 2;
	localparam int PW  = GRAD_W + OW;
	localparam int SW  = PW + 2;
	localparam int DW  = SW - FB;
	localparam int WW  = FB + 1;
	localparam int MW  = WW + 1 + DW;
	localparam int AW  = MW + 3;
	localparam int NW  = AW - FB;
	localparam int OCW = $clog2(MAX_OCTAVES + 1);
	localparam int TAW = NW + MAX_OCTAVES + OCW + 1;
	localparam int STW = 5;

	localparam logic [STW-1:0] STEP_CORNER_FIRST = 5'd7;
	localparam logic [STW-1:0] STEP_CORNER_LAST  = 5'd14;
	localparam logic [STW-1:0] STEP_END          = 5'd19;

	localparam logic [WW-1:0]  ONE_W   = {1'b1, {FB{1'b0}}};
	localparam logic [OW-1:0]  ONE_O   = {2'b01, {FB{1'b0}}};
	localparam logic [FB+1:0]  THREE_F = {2'b11, {FB{1'b0}}};
	localparam logic signed [TAW-1:0] R_MAX = TAW'(OUT_MAX);
	localparam logic signed [TAW-1:0] R_MIN = TAW'(OUT_MIN);

	state_t state_q, state_d;
	logic [STW-1:0] step_q;
	logic [OCW-1:0] oct_q, noct_q, noct_d;
	logic turb_q;
	logic [OCT_CNT_W-1:0] octcnt_q;
	logic done_q;
	logic signed [OUT_W-1:0] nv_q;

	logic accept;
	cmd_t cmd_in;
	logic [XW-1:0] idx_ext;
	logic [TW-1:0] idx;

	cmd_t ld_cmd_q;
	logic [TW-1:0] ld_idx_q;
	logic [PERM_W-1:0] ld_val_q;

	logic p_we;
	logic [TW-1:0] p_raddr;
	logic [3*PERM_W-1:0] p_wdata, p_rdata;
	logic g_we;
	logic [TW-1:0] g_raddr;
	logic [3*GRAD_W-1:0] g_rdata;

	logic [CW-1:0] c_q [3];
	logic [FB-1:0] f2_q [3];
	logic [FB:0] s_q [3];
	logic [WW-1:0] w0_q [3];
	logic [WW-1:0] w1_q [3];

	logic [PERM_W-1:0] px0_q, px1_q, py0_q, py1_q, pz0_q, pz1_q;

	logic issue;
	logic [STW-1:0] kdiff;
	logic [2:0] kc;
	logic [PERM_W-1:0] hash8;
	logic [HW-1:0] hash_ext;
	logic iss_v_q;
	logic [2:0] iss_k_q;

	logic [OW-1:0] ox_u, oy_u, oz_u;
	logic [WW-1:0] wx, wy, wz;
	logic signed [PW-1:0] gpx_s1, gpy_s1, gpz_s1;
	logic [2*WW-1:0] wxy_s1;
	logic [WW-1:0] wz_s1;
	logic v_s1;
	logic signed [SW-1:0] dsum;
	logic [2*WW-1:0] wprod;
	logic signed [DW-1:0] dot_s2;
	logic [WW-1:0] w_s2;
	logic v_s2;
	logic signed [MW-1:0] term_s3;
	logic v_s3;
	logic signed [AW-1:0] acc_q;
	logic signed [NW-1:0] noise, noise_q;
	logic signed [TAW-1:0] tacc_q, tabs, rwide;
	logic [OCW-1:0] shamt;
	logic last_oct;

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign noise_value = nv_q;
	assign accept = start && !busy;
	assign cmd_in = cmd_t'(cmd);
	assign idx_ext = XW'(entry_index);
	assign idx    = idx_ext[TW-1:0];

	always_comb begin
		if (!turb_q) begin
			noct_d = OCW'(1);
		end else if (int'(octcnt_q) > MAX_OCTAVES) begin
			noct_d = OCW'(MAX_OCTAVES);
		end else begin
			noct_d = OCW'(octcnt_q);
		end
	end

	assign last_oct = ((oct_q + OCW'(1)) == noct_q);

	// state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (cmd_in)
						CMD_EVAL: state_d = (noct_d == '0) ? S_FIN : S_RUN;
						CMD_LOAD_PX, CMD_LOAD_PY, CMD_LOAD_PZ: state_d = S_LDW;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_LDW: state_d = S_IDLE;
			S_RUN: begin
				if (step_q == STEP_END && last_oct) begin
					state_d = S_FIN;
				end
			end
			S_FIN: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= '0;
			oct_q    <= '0;
			noct_q   <= '0;
			turb_q   <= 1'b0;
			octcnt_q <= OCT_CNT_RST;
			done_q   <= 1'b0;
			iss_v_q  <= 1'b0;
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
		end else begin
			done_q  <= (state_q == S_FIN);
			iss_v_q <= issue;
			v_s1    <= iss_v_q;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_TURB: turb_q <= cfg_data[0];
					CFG_OCT:  octcnt_q <= cfg_data;
					default: ;
				endcase
			end
			if (accept && cmd_in == CMD_EVAL) begin
				step_q <= '0;
				oct_q  <= '0;
				noct_q <= noct_d;
			end else if (state_q == S_RUN) begin
				if (step_q == STEP_END) begin
					step_q <= '0;
					oct_q  <= oct_q + OCW'(1);
				end else begin
					step_q <= step_q + STW'(1);
				end
			end
		end
	end

	// table memories
	always_ff @(posedge clk) begin
		if (accept) begin
			ld_cmd_q <= cmd_in;
			ld_idx_q <= idx;
			ld_val_q <= perm_entry;
		end
	end

	always_comb begin
		p_raddr = idx;
		if (state_q == S_RUN) begin
			case (step_q)
				5'd0: p_raddr = c_q[0][CW-1:FB];
				5'd1: p_raddr = c_q[0][CW-1:FB] + TW'(1);
				5'd2: p_raddr = c_q[1][CW-1:FB];
				5'd3: p_raddr = c_q[1][CW-1:FB] + TW'(1);
				5'd4: p_raddr = c_q[2][CW-1:FB];
				default: p_raddr = c_q[2][CW-1:FB] + TW'(1);
			endcase
		end
	end

	always_comb begin
		p_wdata = p_rdata;
		case (ld_cmd_q)
			CMD_LOAD_PX: p_wdata[PERM_W-1:0] = ld_val_q;
			CMD_LOAD_PY: p_wdata[2*PERM_W-1:PERM_W] = ld_val_q;
			default:     p_wdata[3*PERM_W-1:2*PERM_W] = ld_val_q;
		endcase
	end

	assign p_we = (state_q == S_LDW);
	assign g_we = accept && (cmd_in == CMD_LOAD_GRAD);

	gnt_ram #(.WIDTH(3*PERM_W), .DEPTH(TABLE_SIZE)) u_perm_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (ld_idx_q),
		.wdata (p_wdata),
		.raddr (p_raddr),
		.rdata (p_rdata)
	);

	gnt_ram #(.WIDTH(3*GRAD_W), .DEPTH(TABLE_SIZE)) u_grad_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (idx),
		.wdata ({grad_z, grad_y, grad_x}),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	// coordinates and smoothing
	always_ff @(posedge clk) begin
		if (accept && cmd_in == CMD_EVAL) begin
			c_q[0] <= CW'(coord_x);
			c_q[1] <= CW'(coord_y);
			c_q[2] <= CW'(coord_z);
		end else if (state_q == S_RUN && step_q == STEP_END) begin
			c_q[0] <= c_q[0] << 1;
			c_q[1] <= c_q[1] << 1;
			c_q[2] <= c_q[2] << 1;
		end
	end

	for (genvar ax = 0; ax < 3; ax++) begin : g_axis
		logic [FB-1:0] f;
		logic [2*FB-1:0] ff;
		logic [FB+1:0] t;
		logic [2*FB+1:0] sp;
		assign f  = c_q[ax][FB-1:0];
		assign ff = f * f;
		assign t  = THREE_F - {1'b0, f, 1'b0};
		assign sp = f2_q[ax] * t;
		always_ff @(posedge clk) begin
			f2_q[ax] <= ff[2*FB-1:FB];
			s_q[ax]  <= sp[2*FB:FB];
			w1_q[ax] <= s_q[ax];
			w0_q[ax] <= ONE_W - s_q[ax];
		end
	end

	// perm capture
	always_ff @(posedge clk) begin
		if (state_q == S_RUN) begin
			case (step_q)
				5'd1: px0_q <= p_rdata[PERM_W-1:0];
				5'd2: px1_q <= p_rdata[PERM_W-1:0];
				5'd3: py0_q <= p_rdata[2*PERM_W-1:PERM_W];
				5'd4: py1_q <= p_rdata[2*PERM_W-1:PERM_W];
				5'd5: pz0_q <= p_rdata[3*PERM_W-1:2*PERM_W];
				5'd6: pz1_q <= p_rdata[3*PERM_W-1:2*PERM_W];
				default: ;
			endcase
		end
	end

	// corner issue
	assign issue = (state_q == S_RUN) && (step_q >= STEP_CORNER_FIRST)
		&& (step_q <= STEP_CORNER_LAST);
	assign kdiff = step_q - STEP_CORNER_FIRST;
	assign kc    = kdiff[2:0];
	assign hash8 = (kc[2] ? px1_q : px0_q) ^ (kc[1] ? py1_q : py0_q) ^ (kc[0] ? pz1_q : pz0_q);
	assign hash_ext = HW'(hash8);
	assign g_raddr  = hash_ext[TW-1:0];

	always_ff @(posedge clk) begin
		iss_k_q <= kc;
	end

	// corner pipeline
	assign ox_u = {2'b00, c_q[0][FB-1:0]} - (iss_k_q[2] ? ONE_O : '0);
	assign oy_u = {2'b00, c_q[1][FB-1:0]} - (iss_k_q[1] ? ONE_O : '0);
	assign oz_u = {2'b00, c_q[2][FB-1:0]} - (iss_k_q[0] ? ONE_O : '0);
	assign wx = iss_k_q[2] ? w1_q[0] : w0_q[0];
	assign wy = iss_k_q[1] ? w1_q[1] : w0_q[1];
	assign wz = iss_k_q[0] ? w1_q[2] : w0_q[2];

	assign dsum = SW'(gpx_s1) + SW'(gpy_s1) + SW'(gpz_s1);
	assign wprod = wxy_s1[FB+WW-1:FB] * wz_s1;

	always_ff @(posedge clk) begin
		gpx_s1  <= $signed(g_rdata[GRAD_W-1:0]) * $signed(ox_u);
		gpy_s1  <= $signed(g_rdata[2*GRAD_W-1:GRAD_W]) * $signed(oy_u);
		gpz_s1  <= $signed(g_rdata[3*GRAD_W-1:2*GRAD_W]) * $signed(oz_u);
		wxy_s1  <= wx * wy;
		wz_s1   <= wz;
		dot_s2  <= dsum[SW-1:FB];
		w_s2    <= wprod[FB+WW-1:FB];
		term_s3 <= $signed({1'b0, w_s2}) * dot_s2;
	end

	// octave accumulation
	assign noise = acc_q[AW-1:FB];
	assign shamt = OCW'(MAX_OCTAVES) - oct_q;

	always_ff @(posedge clk) begin
		if (accept && cmd_in == CMD_EVAL) begin
			acc_q  <= '0;
			tacc_q <= '0;
		end else if (state_q == S_RUN && step_q == STEP_END) begin
			acc_q   <= '0;
			noise_q <= noise;
			tacc_q  <= tacc_q + (TAW'(noise) <<< shamt);
		end else if (v_s3) begin
			acc_q <= acc_q + AW'(term_s3);
		end
	end

	// result
	assign tabs  = (tacc_q < 0) ? -tacc_q : tacc_q;
	assign rwide = turb_q ? (tabs >>> MAX_OCTAVES) : TAW'(noise_q);

	always_ff @(posedge clk) begin
		if (state_q == S_FIN) begin
			if (rwide > R_MAX) begin
				nv_q <= OUT_W'(OUT_MAX);
			end else if (rwide < R_MIN) begin
				nv_q <= OUT_W'(OUT_MIN);
			end else begin
				nv_q <= rwide[OUT_W-1:0];
			end
		end
	end

	`GNT_ASSERT_IMP(a_done_idle, clk, arst_n, done_q, state_q == S_IDLE)
	`GNT_ASSERT_NXT(a_eval_busy, clk, arst_n, accept && cmd_in == CMD_EVAL, busy)
	`GNT_ASSERT_IMP(a_pipe_run, clk, arst_n, v_s3, state_q == S_RUN)
	`GNT_ASSERT_NXT(a_ldw_once, clk, arst_n, state_q == S_LDW, state_q == S_IDLE)

endmodule

### bench/tb_gradient_noise_turbulence.sv
// Testbench for gradient_noise_turbulence: loads the permutation and gradient tables,
// then checks directed and random evaluates in plain and turbulence mode against a predictor.
// Depends on gnt_pkg and the gradient_noise_turbulence RTL.
`timescale 1ns / 1ps

module tb_gradient_noise_turbulence;
	import gnt_pkg::*;

	localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
	localparam int DRAIN_CYCLES = 250;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done;
	logic [CMD_W-1:0] cmd = '0;
	logic signed [COORD_W-1:0] coord_x = '0, coord_y = '0, coord_z = '0;
	logic [IDX_W-1:0] entry_index = '0;
	logic [PERM_W-1:0] perm_entry = '0;
	logic signed [GRAD_W-1:0] grad_x = '0, grad_y = '0, grad_z = '0;
	logic signed [OUT_W-1:0] noise_value;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	gradient_noise_turbulence dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.cmd(cmd), .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
		.entry_index(entry_index), .perm_entry(perm_entry),
		.grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z),
		.noise_value(noise_value),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	logic [PERM_W-1:0] px_mirror[TABLE_SIZE_DEF];
	logic [PERM_W-1:0] py_mirror[TABLE_SIZE_DEF];
	logic [PERM_W-1:0] pz_mirror[TABLE_SIZE_DEF];
	longint gx_mirror[TABLE_SIZE_DEF];
	longint gy_mirror[TABLE_SIZE_DEF];
	longint gz_mirror[TABLE_SIZE_DEF];
	logic turb_mirror = 1'b0;
	logic [OCT_CNT_W-1:0] oct_mirror = OCT_CNT_RST;

	logic signed [OUT_W-1:0] noise_expected[$];
	int errors = 0;
	int n_eval = 0, n_load = 0, n_results = 0;
	int gap_pct = 0;
	bit drain_each = 0;
	int idle_cycles = 0;

	function automatic longint octave_noise(longint cx, longint cy, longint cz);
		longint c[3], f[3], s[3], f2, acc, dot, w, wx, wy, wz, ox, oy, oz;
		int b[3][2];
		int h;
		c[0] = cx; c[1] = cy; c[2] = cz;
		acc = 0;
		for (int a = 0; a < 3; a++) begin
			f[a] = c[a] & 64'hFFFF;
			b[a][0] = int'((c[a] >>> 16) & 255);
			b[a][1] = int'(((c[a] >>> 16) + 1) & 255);
			f2 = (f[a] * f[a]) >>> 16;
			s[a] = (f2 * (3 * 65536 - 2 * f[a])) >>> 16;
		end
		for (int a = 0; a < 2; a++)
			for (int d = 0; d < 2; d++)
				for (int e = 0; e < 2; e++) begin
					h = px_mirror[b[0][a]] ^ py_mirror[b[1][d]] ^ pz_mirror[b[2][e]];
					ox = f[0] - a * 65536;
					oy = f[1] - d * 65536;
					oz = f[2] - e * 65536;
					dot = (gx_mirror[h] * ox + gy_mirror[h] * oy + gz_mirror[h] * oz) >>> 16;
					wx = a ? s[0] : 65536 - s[0];
					wy = d ? s[1] : 65536 - s[1];
					wz = e ? s[2] : 65536 - s[2];
					w = (((wx * wy) >>> 16) * wz) >>> 16;
					acc += w * dot;
				end
		return acc >>> 16;
	endfunction

	function automatic logic signed [OUT_W-1:0] predict_noise(longint cx, longint cy, longint cz);
		longint r, acc;
		int n;
		if (!turb_mirror) begin
			r = octave_noise(cx, cy, cz);
		end else begin
			n = (oct_mirror > MAX_OCT_DEF) ? MAX_OCT_DEF : oct_mirror;
			acc = 0;
			for (int o = 0; o < n; o++) begin
				acc += octave_noise(cx, cy, cz) * (longint'(1) << (MAX_OCT_DEF - o));
				cx *= 2; cy *= 2; cz *= 2;
			end
			if (acc < 0) acc = -acc;
			r = acc >>> MAX_OCT_DEF;
		end
		if (r > OUT_MAX) r = OUT_MAX;
		if (r < OUT_MIN) r = OUT_MIN;
		return r[OUT_W-1:0];
	endfunction

	task automatic wait_drained();
		while (noise_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic send_item(logic [CMD_W-1:0] c, logic signed [COORD_W-1:0] x,
			logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z,
			logic [IDX_W-1:0] idx, logic [PERM_W-1:0] pv,
			logic signed [GRAD_W-1:0] gxv, logic signed [GRAD_W-1:0] gyv,
			logic signed [GRAD_W-1:0] gzv);
		if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		cmd <= c; coord_x <= x; coord_y <= y; coord_z <= z;
		entry_index <= idx; perm_entry <= pv;
		grad_x <= gxv; grad_y <= gyv; grad_z <= gzv;
		do @(posedge clk); while (busy);
		case (c)
			CMD_EVAL: begin
				noise_expected.push_back(predict_noise(x, y, z));
				n_eval++;
			end
			CMD_LOAD_PX: begin px_mirror[idx] = pv; n_load++; end
			CMD_LOAD_PY: begin py_mirror[idx] = pv; n_load++; end
			CMD_LOAD_PZ: begin pz_mirror[idx] = pv; n_load++; end
			CMD_LOAD_GRAD: begin
				gx_mirror[idx] = gxv; gy_mirror[idx] = gyv; gz_mirror[idx] = gzv;
				n_load++;
			end
			default: ;
		endcase
		if (drain_each && c == CMD_EVAL) begin
			start <= 1'b0;
			while (noise_expected.size() != 0) @(posedge clk);
		end
	endtask

	task automatic write_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		start <= 1'b0;
		wait_drained();
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_TURB) turb_mirror = val[0];
		else if (idx == CFG_OCT) oct_mirror = val;
	endtask

	function automatic logic signed [GRAD_W-1:0] rand_grad();
		return GRAD_W'($signed($urandom_range(32768)) - 16384);
	endfunction

	task automatic eval_at(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
			logic signed [COORD_W-1:0] z);
		send_item(CMD_EVAL, x, y, z, $urandom, $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic rand_load();
		logic [CMD_W-1:0] c;
		c = $urandom_range(CMD_LOAD_PX, CMD_LOAD_GRAD);
		send_item(c, $urandom, $urandom, $urandom, $urandom, $urandom,
			rand_grad(), rand_grad(), rand_grad());
	endtask

	function automatic logic signed [COORD_W-1:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return COORD_W'($signed($urandom_range(32'h00FF_FFFF)) - 32'sh0080_0000);
			2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
			default: return {16'($urandom_range(3)) + 16'h00FF, 16'($urandom)};
		endcase
	endfunction

	task automatic test_load_tables();
		for (int i = 0; i < TABLE_SIZE_DEF; i++) begin
			send_item(CMD_LOAD_PX, $urandom, $urandom, $urandom, i[7:0],
				(i == 0) ? 8'd0 : (i == 1) ? 8'd255 : 8'($urandom), 0, 0, 0);
			send_item(CMD_LOAD_PY, $urandom, $urandom, $urandom, i[7:0], $urandom, 0, 0, 0);
			send_item(CMD_LOAD_PZ, $urandom, $urandom, $urandom, i[7:0], $urandom, 0, 0, 0);
			send_item(CMD_LOAD_GRAD, $urandom, $urandom, $urandom, i[7:0], $urandom,
				(i < 2) ? -16'sd16384 : rand_grad(),
				(i < 2) ? 16'sd16384 : rand_grad(),
				(i == 2) ? 16'sd16384 : rand_grad());
		end
	endtask

	task automatic test_directed_eval();
		eval_at(0, 0, 0);
		eval_at(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		eval_at(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
		eval_at(-1, -1, -1);
		eval_at(32'sh0000_FFFF, 32'sh0000_8000, 32'sh0000_0001);
		eval_at(32'sh00FF_8000, 32'shFF00_4000, 32'sh0100_C000);
		eval_at(32'sh7FFF_0000, 32'sh8000_FFFF, 32'sh0000_0000);
		eval_at(32'shFFFF_0000, 32'sh0001_0000, 32'sh5555_AAAA);
		send_item(CMD_RSVD_LO, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
		send_item(CMD_RSVD_HI, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
		send_item(CMD_RSVD_LO + 1, $urandom, $urandom, $urandom, $urandom, $urandom, 0, 0, 0);
		eval_at(32'sh0001_2345, 32'shFFFE_DCBA, 32'sh0000_7FFF);
	endtask

	task automatic test_octave_settings();
		logic [CFG_DATA_W-1:0] counts[6] = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15, 4'd3};
		write_config(CFG_TURB, 4'd1);
		for (int k = 0; k < 6; k++) begin
			write_config(CFG_OCT, counts[k]);
			eval_at(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_FFFF);
			eval_at(rand_coord(), rand_coord(), rand_coord());
			eval_at(-1, 32'sh0000_8000, 32'sh00FF_C000);
		end
		write_config(CFG_TURB, 4'd0);
	endtask

	task automatic test_random(int items, int pct, bit drain);
		gap_pct = pct;
		drain_each = drain;
		for (int i = 0; i < items; i++) begin
			case ($urandom_range(19))
				0, 1, 2: rand_load();
				3: send_item($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI), $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
				default: eval_at(rand_coord(), rand_coord(), rand_coord());
			endcase
		end
		drain_each = 0;
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			n_results++;
			if (noise_expected.size() == 0) begin
				$error("noise_value: no result expected, got %0d", noise_value);
				errors++;
			end else begin
				if (noise_value !== noise_expected[0]) begin
					$error("noise_value: expected %0d, got %0d", noise_expected[0], noise_value);
					errors++;
				end
				void'(noise_expected.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired, %0d results outstanding", noise_expected.size());
			$display("[gradient_noise_turbulence] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_load_tables();
		test_directed_eval();
		test_octave_settings();
		test_random(30, 0, 0);
		write_config(CFG_TURB, 4'd1);
		write_config(CFG_OCT, 4'd2);
		test_random(20, 67, 0);
		write_config(CFG_OCT, 4'd8);
		test_random(10, 12, 1);
		write_config(CFG_TURB, 4'd0);
		write_config(CFG_OCT, 4'd1);
		test_random(30, 67, 0);
		test_random(10, 12, 0);
		start <= 1'b0;
		wait_drained();
		$display("covered %0d evaluates and %0d table loads, %0d results checked,",
			n_eval, n_load, n_results);
		$display("plain and turbulence modes with octave counts from zero to fifteen");
		if (errors == 0 && noise_expected.size() == 0)
			$display("[gradient_noise_turbulence] OK");
		else
			$display("[gradient_noise_turbulence] ERROR");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/gnt_pkg.sv
rtl/gnt_ram.sv
rtl/gradient_noise_turbulence.sv
bench/tb_gradient_noise_turbulence.sv
